// ----- hw/rtl/mbea_pkg.sv -----
// Package for the mouse button event block with autorepeat.
// Holds the payload structs, the event codes and the register indexes.
// No dependencies.
package mbea_pkg;

  localparam int CFG_IDX_BITS = 8;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_INITIAL_DELAY = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REPEAT_DELAY  = 8'd1;

  localparam logic [15:0] INITIAL_DELAY_RESET = 16'd200;
  localparam logic [15:0] REPEAT_DELAY_RESET  = 16'd25;

  typedef enum logic [3:0] {
    EV_NONE       = 4'd0,
    EV_MOVE       = 4'd1,
    EV_BOTH_UP    = 4'd2,
    EV_LEFT_UP    = 4'd3,
    EV_RIGHT_UP   = 4'd4,
    EV_LEFT_DOWN  = 4'd5,
    EV_RIGHT_DOWN = 4'd6,
    EV_BOTH_DOWN  = 4'd7,
    EV_BOTH_REP   = 4'd8,
    EV_LEFT_REP   = 4'd9,
    EV_RIGHT_REP  = 4'd10
  } mbea_event_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               left_pressed;
    logic               right_pressed;
    logic [31:0]        time_ms;
  } mbea_in_t;

  typedef struct packed {
    mbea_event_t event_res;
    logic        left_held;
    logic        right_held;
  } mbea_out_t;

endpackage

// ----- hw/rtl/mbea_core.sv -----
// Event logic and button/timer state for the mouse button event block.
// Takes one registered sample per fire and produces its result combinationally.
// Depends on mbea_pkg.
module mbea_core
  import mbea_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     fire,
  input  mbea_in_t                 item,
  output mbea_out_t                result
);

  logic [15:0]           initial_delay;
  logic [15:0]           repeat_delay;
  logic                  left_latched, right_latched, both_latched;
  logic [COORD_BITS-1:0] last_x, last_y;
  logic [31:0]           timer_mark;
  logic [15:0]           current_delay;

  logic                  left_latched_next, right_latched_next, both_latched_next;
  logic [COORD_BITS-1:0] last_x_next, last_y_next;
  logic [31:0]           timer_mark_next;
  logic [15:0]           current_delay_next;

  logic [31:0]           x_wide, y_wide;
  logic [COORD_BITS-1:0] x_now, y_now;
  logic                  lk, rk;
  logic [31:0]           elapsed;
  logic                  expired;
  mbea_event_t           code;

  // Coordinates are sign-extended and then kept at the stored width.
  assign x_wide  = 32'(item.pos_x);
  assign y_wide  = 32'(item.pos_y);
  assign x_now   = x_wide[COORD_BITS-1:0];
  assign y_now   = y_wide[COORD_BITS-1:0];
  assign lk      = item.left_pressed;
  assign rk      = item.right_pressed;
  assign elapsed = item.time_ms - timer_mark;
  assign expired = elapsed > {16'd0, current_delay};

  always_comb begin
    code               = EV_NONE;
    left_latched_next  = left_latched;
    right_latched_next = right_latched;
    both_latched_next  = both_latched;
    last_x_next        = last_x;
    last_y_next        = last_y;
    timer_mark_next    = timer_mark;
    current_delay_next = current_delay;

    if (x_now != last_x || y_now != last_y) begin
      code        = EV_MOVE;
      last_x_next = x_now;
      last_y_next = y_now;
    end

    // Only the first transition that applies is taken; the rest follow
    // in later samples.
    if (both_latched && !(lk && rk)) begin
      both_latched_next = 1'b0;
      code              = EV_BOTH_UP;
    end else if (left_latched && !lk) begin
      left_latched_next = 1'b0;
      code              = EV_LEFT_UP;
    end else if (right_latched && !rk) begin
      right_latched_next = 1'b0;
      code               = EV_RIGHT_UP;
    end else if (!left_latched && lk) begin
      left_latched_next = 1'b1;
      code              = EV_LEFT_DOWN;
    end else if (!right_latched && rk) begin
      right_latched_next = 1'b1;
      code               = EV_RIGHT_DOWN;
    end else if (!both_latched && lk && rk) begin
      both_latched_next = 1'b1;
      code              = EV_BOTH_DOWN;
    end else if ((lk || rk) && expired) begin
      timer_mark_next    = item.time_ms;
      current_delay_next = repeat_delay;
      if (lk && rk) begin
        code = EV_BOTH_REP;
      end else if (lk) begin
        code = EV_LEFT_REP;
      end else begin
        code = EV_RIGHT_REP;
      end
    end

    if (code inside {[EV_BOTH_UP:EV_BOTH_DOWN]}) begin
      timer_mark_next    = item.time_ms;
      current_delay_next = initial_delay;
    end
  end

  assign result.event_res  = code;
  assign result.left_held  = lk;
  assign result.right_held = rk;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_delay <= INITIAL_DELAY_RESET;
      repeat_delay  <= REPEAT_DELAY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INITIAL_DELAY: initial_delay <= cfg_data;
        CFG_REPEAT_DELAY:  repeat_delay  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_latched  <= 1'b0;
      right_latched <= 1'b0;
      both_latched  <= 1'b0;
      last_x        <= '1;
      last_y        <= '1;
      timer_mark    <= '0;
      current_delay <= INITIAL_DELAY_RESET;
    end else if (fire) begin
      left_latched  <= left_latched_next;
      right_latched <= right_latched_next;
      both_latched  <= both_latched_next;
      last_x        <= last_x_next;
      last_y        <= last_y_next;
      timer_mark    <= timer_mark_next;
      current_delay <= current_delay_next;
    end
  end

`ifndef SYNTH
  // The both flag can only be set on top of the two single flags.
  a_both_implies_single: assert property (@(posedge clk) disable iff (rst)
    both_latched |-> (left_latched && right_latched))
    else $error("both_latched set without both single flags");

  a_transition_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && (code == EV_BOTH_UP || code == EV_LEFT_UP || code == EV_RIGHT_UP ||
             code == EV_LEFT_DOWN || code == EV_RIGHT_DOWN || code == EV_BOTH_DOWN)
    |=> (timer_mark == $past(item.time_ms)) && (current_delay == $past(initial_delay)))
    else $error("button transition did not restart the timer");

  a_repeat_reloads: assert property (@(posedge clk) disable iff (rst)
    fire && (code == EV_BOTH_REP || code == EV_LEFT_REP || code == EV_RIGHT_REP)
    |=> (timer_mark == $past(item.time_ms)) && (current_delay == $past(repeat_delay)))
    else $error("repeat event did not reload the repeat delay");

  a_repeat_needs_button: assert property (@(posedge clk) disable iff (rst)
    (code == EV_BOTH_REP || code == EV_LEFT_REP || code == EV_RIGHT_REP)
    |-> (lk || rk) && expired)
    else $error("repeat event with no button held or timer not expired");
`endif

endmodule

// ----- hw/rtl/mouse_button_event_autorepeat.sv -----
// Mouse button event generator with autorepeat: one event per poll sample.
// The result is registered: a sample passes the input register, then the result
// register, and the event logic sits between the two.
// Throughput: one sample per cycle while out_stall is low, set by the single pass of
// event logic between the two registers. Reset (rst, synchronous) clears the button flags
// and timer mark, sets both coordinates to -1, the delays to 200 and 25 ms.
module mouse_button_event_autorepeat
  import mbea_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  mbea_in_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output mbea_out_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic      s1_valid;
  mbea_in_t  s1_data;
  logic      out_load;
  logic      in_fire;
  mbea_out_t core_result;

  // The sample moves on whenever the result register is empty or being drained.
  assign out_load = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !out_load;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data <= in_data;
    end
  end

  mbea_core #(
    .COORD_BITS(COORD_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .fire     (out_load),
    .item     (s1_data),
    .result   (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= core_result;
    end
  end

endmodule

// ----- tb/mouse_button_event_autorepeat_tb.sv -----
// Self-checking testbench for mouse_button_event_autorepeat: a directed table, then random
// poll samples under four idling patterns; results match a behavioral predictor or a typed row.
// Depends on mbea_pkg and the block's RTL.
module mouse_button_event_autorepeat_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mbea_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_PER_PHASE = 155;
  localparam int MAX_PRINTED = 100;
  // No register lives at this index, so a write to it must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED = CFG_REPEAT_DELAY + 8'd1;

  typedef struct {
    mbea_in_t    sample;
    bit          typed;
    mbea_event_t typed_event;
  } poll_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  mbea_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mbea_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Predictor state and its copy of the delay registers.
  logic        lat_left, lat_right, lat_both;
  logic [15:0] last_x, last_y;
  logic [31:0] timer_mark;
  logic [15:0] cur_delay, initial_delay, repeat_delay;

  mbea_out_t expected_events[$];
  poll_row_t poll_rows[$];
  int mismatches = 0;
  int results_seen = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  // Random sample generator cursor.
  logic [31:0] gen_time = '0;
  logic [15:0] gen_x = '0, gen_y = '0;
  logic        gen_left = 1'b0, gen_right = 1'b0;

  mouse_button_event_autorepeat dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) $display("MISMATCH at result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    mbea_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        report_mismatch("result with no sample waiting for one");
      end else begin
        want = expected_events.pop_front();
        if (out_data.event_res !== want.event_res)
          report_mismatch($sformatf("event_res got %0d want %0d", out_data.event_res,
                                    want.event_res));
        if (out_data.left_held !== want.left_held)
          report_mismatch($sformatf("left_held got %b want %b", out_data.left_held,
                                    want.left_held));
        if (out_data.right_held !== want.right_held)
          report_mismatch($sformatf("right_held got %b want %b", out_data.right_held,
                                    want.right_held));
      end
      results_seen++;
    end
  end

  task automatic reset_predictor();
    lat_left = 1'b0;
    lat_right = 1'b0;
    lat_both = 1'b0;
    last_x = 16'hFFFF;
    last_y = 16'hFFFF;
    timer_mark = '0;
    initial_delay = INITIAL_DELAY_RESET;
    repeat_delay = REPEAT_DELAY_RESET;
    cur_delay = INITIAL_DELAY_RESET;
  endtask

  function automatic void restart_timer(input logic [31:0] now);
    timer_mark = now;
    cur_delay = initial_delay;
  endfunction

  function automatic mbea_out_t predict_event(input mbea_in_t s);
    mbea_out_t ev;
    logic [31:0] elapsed;
    logic lk, rk;
    lk = s.left_pressed;
    rk = s.right_pressed;
    ev.event_res = EV_NONE;
    ev.left_held = lk;
    ev.right_held = rk;
    if (s.pos_x != last_x || s.pos_y != last_y) begin
      ev.event_res = EV_MOVE;
      last_x = s.pos_x;
      last_y = s.pos_y;
    end
    // Only the first transition in this order is taken; the rest follow in later samples.
    if (lat_both && !(lk && rk)) begin
      lat_both = 1'b0; ev.event_res = EV_BOTH_UP; restart_timer(s.time_ms);
    end else if (lat_left && !lk) begin
      lat_left = 1'b0; ev.event_res = EV_LEFT_UP; restart_timer(s.time_ms);
    end else if (lat_right && !rk) begin
      lat_right = 1'b0; ev.event_res = EV_RIGHT_UP; restart_timer(s.time_ms);
    end else if (!lat_left && lk) begin
      lat_left = 1'b1; ev.event_res = EV_LEFT_DOWN; restart_timer(s.time_ms);
    end else if (!lat_right && rk) begin
      lat_right = 1'b1; ev.event_res = EV_RIGHT_DOWN; restart_timer(s.time_ms);
    end else if (!lat_both && lk && rk) begin
      lat_both = 1'b1; ev.event_res = EV_BOTH_DOWN; restart_timer(s.time_ms);
    end else if (lk || rk) begin
      elapsed = s.time_ms - timer_mark;
      if (elapsed > {16'd0, cur_delay}) begin
        timer_mark = s.time_ms;
        cur_delay = repeat_delay;
        if (lk && rk) ev.event_res = EV_BOTH_REP;
        else if (lk) ev.event_res = EV_LEFT_REP;
        else ev.event_res = EV_RIGHT_REP;
      end
    end
    return ev;
  endfunction

  // Called at a rising edge; returns at the edge where the sample was taken.
  task automatic send_sample(input mbea_in_t s, input bit typed, input mbea_event_t typed_ev);
    mbea_out_t ev;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ev = predict_event(s);
    if (typed) ev.event_res = typed_ev;
    expected_events.push_back(ev);
  endtask

  // Registers change only with the block drained and the input side quiet.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] val);
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_INITIAL_DELAY) initial_delay = val;
    else if (idx == CFG_REPEAT_DELAY) repeat_delay = val;
  endtask

  task automatic add_row(input logic [15:0] x, input logic [15:0] y, input logic l,
                         input logic r, input logic [31:0] t, input bit typed,
                         input mbea_event_t ev);
    poll_row_t row;
    row.sample.pos_x = x;
    row.sample.pos_y = y;
    row.sample.left_pressed = l;
    row.sample.right_pressed = r;
    row.sample.time_ms = t;
    row.typed = typed;
    row.typed_event = ev;
    poll_rows.push_back(row);
  endtask

  // Mostly plausible polling: buttons held for stretches, time creeping forward near the
  // delays, the pointer mostly still. Now and then the clock jumps anywhere, even backwards.
  task automatic next_random_sample(output mbea_in_t s);
    int pick;
    if ($urandom_range(99) < 15) begin
      gen_left = 1'($urandom_range(1));
      gen_right = 1'($urandom_range(1));
    end
    if ($urandom_range(99) < 25) begin
      gen_x = 16'($urandom);
      gen_y = 16'($urandom);
    end
    pick = $urandom_range(99);
    if (pick < 55) gen_time = gen_time + $urandom_range(int'(repeat_delay) + 2);
    else if (pick < 85) gen_time = gen_time + $urandom_range(int'(initial_delay) + 2);
    else if (pick < 95) gen_time = gen_time + ($urandom_range(1) ? repeat_delay : initial_delay)
                                            + $urandom_range(1);
    else gen_time = $urandom;
    s.pos_x = gen_x;
    s.pos_y = gen_y;
    s.left_pressed = gen_left;
    s.right_pressed = gen_right;
    s.time_ms = gen_time;
  endtask

  initial begin
    int send_pcts[4];
    int stall_pcts[4];
    logic [15:0] init_vals[4];
    logic [15:0] rep_vals[4];
    mbea_in_t s;

    send_pcts = '{0, 56, 0, 26};
    stall_pcts = '{0, 0, 56, 26};
    init_vals = '{16'd0, 16'd65535, 16'd7, 16'd200};
    rep_vals = '{16'd0, 16'd65535, 16'd3, 16'd25};

    // Out of reset the last position is (-1,-1) and the delays are 200 and 25.
    add_row(16'hFFFF, 16'hFFFF, 0, 0, 32'd0, 1, EV_NONE);
    add_row(16'h7FFF, 16'h8000, 0, 0, 32'd1, 1, EV_MOVE);
    add_row(16'h8000, 16'h7FFF, 0, 0, 32'd2, 1, EV_MOVE);
    add_row(16'h8000, 16'h7FFF, 1, 0, 32'd10, 1, EV_LEFT_DOWN);
    // Elapsed equal to the delay is not enough; one more millisecond is.
    add_row(16'h8000, 16'h7FFF, 1, 0, 32'd210, 1, EV_NONE);
    add_row(16'h8000, 16'h7FFF, 1, 0, 32'd211, 1, EV_LEFT_REP);
    add_row(16'h8000, 16'h7FFF, 1, 0, 32'd236, 0, EV_NONE);
    add_row(16'h8000, 16'h7FFF, 1, 0, 32'd237, 0, EV_NONE);
    add_row(16'h8000, 16'h7FFF, 1, 1, 32'd240, 0, EV_NONE);
    add_row(16'h8000, 16'h7FFF, 1, 1, 32'd241, 0, EV_NONE);
    add_row(16'h8000, 16'h7FFF, 1, 1, 32'd442, 0, EV_NONE);
    add_row(16'h0000, 16'h0000, 1, 1, 32'd443, 0, EV_NONE);
    // A repeat replaces a move in the same sample.
    add_row(16'h0001, 16'h0000, 1, 1, 32'd469, 0, EV_NONE);
    add_row(16'h0001, 16'h0000, 0, 0, 32'd470, 0, EV_NONE);
    add_row(16'h0001, 16'h0000, 0, 0, 32'd471, 0, EV_NONE);
    add_row(16'h0001, 16'h0000, 0, 0, 32'd472, 0, EV_NONE);
    add_row(16'h0002, 16'h0000, 0, 0, 32'd473, 0, EV_NONE);
    add_row(16'h0002, 16'h0000, 0, 1, 32'd480, 0, EV_NONE);
    // Time running backwards, then wrapping past zero.
    add_row(16'h0002, 16'h0000, 0, 1, 32'd0, 0, EV_NONE);
    add_row(16'h0002, 16'h0000, 0, 1, 32'hFFFF_FFFF, 0, EV_NONE);
    add_row(16'h0002, 16'h0000, 0, 1, 32'h0000_0019, 0, EV_NONE);
    // A transition replaces a move; both buttons go down and up across several samples.
    add_row(16'h5555, 16'hAAAA, 1, 1, 32'h20, 0, EV_NONE);
    add_row(16'h5555, 16'hAAAA, 1, 1, 32'h21, 0, EV_NONE);
    add_row(16'h5555, 16'hAAAA, 1, 1, 32'h22, 0, EV_NONE);
    add_row(16'h5555, 16'hAAAA, 0, 0, 32'h23, 0, EV_NONE);
    add_row(16'h5555, 16'hAAAA, 0, 0, 32'h24, 0, EV_NONE);
    add_row(16'h5555, 16'hAAAA, 0, 0, 32'h25, 0, EV_NONE);

    reset_predictor();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (poll_rows[i]) send_sample(poll_rows[i].sample, poll_rows[i].typed,
                                       poll_rows[i].typed_event);

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_INITIAL_DELAY, init_vals[ph]);
      write_reg(CFG_REPEAT_DELAY, rep_vals[ph]);
      if (ph == 2) write_reg(CFG_UNMAPPED, 16'd1);
      send_idle_pct = send_pcts[ph];
      stall_pct = stall_pcts[ph];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        next_random_sample(s);
        send_sample(s, 0, EV_NONE);
      end
    end

    in_valid <= 1'b0;
    stall_pct = 0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/mbea_pkg.sv
hw/rtl/mbea_core.sv
hw/rtl/mouse_button_event_autorepeat.sv
tb/mouse_button_event_autorepeat_tb.sv
